### sv/itf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the integer-to-text formatter.
package itf_pkg;

   localparam int MAX_CHARS_DEF   = 64;
   localparam int DIGIT_SLOTS_DEF = 64;
   localparam int VALUE_BITS_DEF  = 64;

   localparam int VALUE_W = 64;
   localparam int RADIX_W = 6;
   localparam int COUNT_W = 6;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 6;
   localparam int POS_W   = 8;
   localparam int CHUNK_W = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;

   localparam logic [DIGIT_W-1:0] HEX_LETTER = 6'd33;
   localparam logic [DIGIT_W-1:0] OCT_LETTER = 6'd24;
   localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERROR,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic layout;
      logic err_send;
   } cmd_type;

   typedef struct packed {
      logic req_bad;
      logic div_done;
      logic quo_zero;
      logic emit_done;
      logic out_free;
   } status_type;

   // Digit value 0..35 to its ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit,
                                                    input logic lower);
      logic [CHAR_W-1:0] letter_base;
      letter_base = lower ? CH_LOWER_A : CH_UPPER_A;
      if (digit < DEC_DIGITS)
         return CH_ZERO + CHAR_W'(digit);
      else
         return letter_base + CHAR_W'(digit - DEC_DIGITS);
   endfunction

endpackage

### sv/itf_div_unit.sv
`timescale 1ns / 1ps
// Iterative divider by a small base: one byte of quotient per cycle, shift path for powers of two.
module itf_div_unit #(
   parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [VALUE_BITS-1:0]             dividend,
   input  logic [itf_pkg::RADIX_W-1:0]       divisor,
   output logic                              done,
   output logic [VALUE_BITS-1:0]             quotient,
   output logic [itf_pkg::DIGIT_W-1:0]       remainder
);
   import itf_pkg::*;

   localparam int CHUNKS = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W  = CHUNKS * CHUNK_W;
   localparam int CIDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   logic                busy_ff;
   logic                done_ff;
   logic [CIDX_W-1:0]   idx_ff;
   logic [DIGIT_W-1:0]  rem_ff;
   logic [PAD_W-1:0]    quo_ff;
   logic [PAD_W-1:0]    dvd_ff;

   logic [PAD_W-1:0]    dvd_pad;
   logic [CIDX_W-1:0]   top_idx;
   logic                is_pow2;
   logic [2:0]          shift_amt;
   logic [PAD_W-1:0]    pow2_quo;
   logic [DIGIT_W-1:0]  pow2_rem;
   logic [CHUNK_W-1:0]  cur_chunk;
   logic [CHUNK_W-1:0]  quo_chunk;
   logic [DIGIT_W-1:0]  rem_in;
   logic [DIGIT_W:0]    trial;
   logic [DIGIT_W-1:0]  part_rem;

   assign dvd_pad = PAD_W'(dividend);

   // highest nonzero byte; bytes above it give zero quotient and no remainder
   always_comb begin
      top_idx = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         if (dvd_pad[c*CHUNK_W +: CHUNK_W] != '0)
            top_idx = CIDX_W'(c);
      end
   end

   assign is_pow2 = ((divisor & (divisor - 1'b1)) == '0);

   always_comb begin
      case (divisor)
         6'd2:    shift_amt = 3'd1;
         6'd4:    shift_amt = 3'd2;
         6'd8:    shift_amt = 3'd3;
         6'd16:   shift_amt = 3'd4;
         6'd32:   shift_amt = 3'd5;
         default: shift_amt = 3'd0;
      endcase
   end

   assign pow2_quo = dvd_pad >> shift_amt;
   assign pow2_rem = dvd_pad[DIGIT_W-1:0] & (divisor - 1'b1);

   assign cur_chunk = dvd_ff[idx_ff*CHUNK_W +: CHUNK_W];

   // restoring division, eight quotient bits
   always_comb begin
      part_rem  = rem_ff;
      quo_chunk = '0;
      trial     = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         trial = {part_rem, cur_chunk[i]};
         if (trial >= {1'b0, divisor}) begin
            trial        = trial - {1'b0, divisor};
            quo_chunk[i] = 1'b1;
         end
         part_rem = trial[DIGIT_W-1:0];
      end
      rem_in = part_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (is_pow2) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && idx_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         if (is_pow2) begin
            quo_ff <= pow2_quo;
            rem_ff <= pow2_rem;
         end else begin
            quo_ff <= '0;
            rem_ff <= '0;
            dvd_ff <= dvd_pad;
            idx_ff <= top_idx;
         end
      end else if (busy_ff) begin
         quo_ff[idx_ff*CHUNK_W +: CHUNK_W] <= quo_chunk;
         rem_ff <= rem_in;
         if (idx_ff != '0)
            idx_ff <= idx_ff - 1'b1;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

### sv/itf_datapath.sv
`timescale 1ns / 1ps
// Datapath: item registers, digit store, field layout, character pipeline and result register.
module itf_datapath #(
   parameter int MAX_CHARS   = itf_pkg::MAX_CHARS_DEF,
   parameter int DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF,
   parameter int VALUE_BITS  = itf_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  itf_pkg::cmd_type              cmd,
   output itf_pkg::status_type           status,
   input  logic [itf_pkg::VALUE_W-1:0]   req_value,
   input  logic [itf_pkg::RADIX_W-1:0]   req_radix,
   input  logic [itf_pkg::COUNT_W-1:0]   req_min_width,
   input  logic [itf_pkg::COUNT_W-1:0]   req_min_digits,
   input  logic                          req_align_left,
   input  logic                          req_show_plus,
   input  logic                          req_show_space,
   input  logic                          req_with_prefix,
   input  logic                          req_zero_fill,
   input  logic                          req_signed_mode,
   input  logic                          req_lower_case,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itf_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_last_char,
   output logic                          rsp_cut_off,
   output logic                          rsp_bad_radix
);
   import itf_pkg::*;

   localparam int DIDX_W = $clog2(DIGIT_SLOTS);
   localparam int ND_W   = $clog2(DIGIT_SLOTS + 1);

   // item registers
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0]    radix_ff;
   logic [COUNT_W-1:0]    width_ff;
   logic [COUNT_W-1:0]    prec_ff;
   logic                  left_ff;
   logic                  zfill_ff;
   logic                  pfx_ff;
   logic                  sign_ff, sign_in;
   logic [CHAR_W-1:0]     sign_char_ff, sign_char_in;
   logic                  lower_ff;
   logic [ND_W-1:0]       nd_ff;

   // layout registers: end position of each segment
   logic [POS_W-1:0] lead_end_ff, lead_end_in;
   logic [POS_W-1:0] sign_end_ff, sign_end_in;
   logic [POS_W-1:0] pfx_end_ff, pfx_end_in;
   logic [POS_W-1:0] prec_end_ff, prec_end_in;
   logic [POS_W-1:0] digit_end_ff, digit_end_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic             cut_ff, cut_in;
   logic             pfx_two_ff;

   // character pipeline
   logic              a_active_ff;
   logic [POS_W-1:0]  k_ff;
   logic              b_valid_ff;
   logic [CHAR_W-1:0] b_char_ff, b_char_in;
   logic              b_digit_ff, b_digit_in;
   logic              b_last_ff, b_last_in;
   logic [DIGIT_W-1:0] mem_rd_ff;
   logic [DIGIT_W-1:0] digit_mem_ff [DIGIT_SLOTS];

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;
   logic              rsp_cut_ff;
   logic              rsp_bad_ff;

   logic [VALUE_BITS-1:0] v_low;
   logic                  neg;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [DIGIT_W-1:0]    div_rem;
   logic [POS_W-1:0]      nd_pos, prec_eff, pfx_len, sign_len, used, width_pos, pad, total;
   logic                  out_free;
   logic                  b_move;
   logic                  issue;
   logic [POS_W-1:0]      rd_pos;
   logic [DIDX_W-1:0]     rd_addr;

   // ---------------------------------------------------------------- capture
   assign v_low = req_value[VALUE_BITS-1:0];
   assign neg   = req_signed_mode & v_low[VALUE_BITS-1];
   // most negative value maps to 2^(VALUE_BITS-1) as an unsigned magnitude
   assign mag_in = neg ? (VALUE_BITS'(0) - v_low) : v_low;

   always_comb begin
      if (req_signed_mode) begin
         sign_in      = neg;
         sign_char_in = CH_MINUS;
      end else begin
         sign_in      = req_show_plus | req_show_space;
         sign_char_in = req_show_plus ? CH_PLUS : CH_SPACE;
      end
   end

   itf_div_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (mag_ff),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff       <= mag_in;
         radix_ff     <= req_radix;
         width_ff     <= req_min_width;
         prec_ff      <= req_min_digits;
         left_ff      <= req_align_left;
         zfill_ff     <= req_zero_fill & ~req_align_left;
         pfx_ff       <= req_with_prefix;
         sign_ff      <= sign_in;
         sign_char_ff <= sign_char_in;
         lower_ff     <= req_lower_case;
      end else if (div_done) begin
         mag_ff <= div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff <= '0;
      end else if (cmd.capture) begin
         nd_ff <= '0;
      end else if (div_done) begin
         nd_ff <= nd_ff + 1'b1;
      end
   end

   // ----------------------------------------------------------------- layout
   assign nd_pos    = POS_W'(nd_ff);
   assign prec_eff  = (nd_pos > POS_W'(prec_ff)) ? nd_pos : POS_W'(prec_ff);
   assign sign_len  = POS_W'(sign_ff);
   assign width_pos = POS_W'(width_ff);

   always_comb begin
      pfx_len = '0;
      if (pfx_ff) begin
         if (radix_ff == RADIX_HEX)
            pfx_len = POS_W'(2);
         else if (radix_ff == RADIX_OCT)
            pfx_len = POS_W'(1);
      end
   end

   assign used  = sign_len + pfx_len + prec_eff;
   assign pad   = (width_pos > used) ? (width_pos - used) : '0;
   assign total = used + pad;

   always_comb begin
      lead_end_in  = (!left_ff && !zfill_ff) ? pad : '0;
      sign_end_in  = lead_end_in + sign_len;
      pfx_end_in   = sign_end_in + pfx_len;
      prec_end_in  = pfx_end_in + (zfill_ff ? pad : '0) + (prec_eff - nd_pos);
      digit_end_in = prec_end_in + nd_pos;
      cut_in       = total > POS_W'(MAX_CHARS);
      count_in     = cut_in ? POS_W'(MAX_CHARS) : total;
   end

   always_ff @(posedge clock) begin
      if (cmd.layout) begin
         lead_end_ff  <= lead_end_in;
         sign_end_ff  <= sign_end_in;
         pfx_end_ff   <= pfx_end_in;
         prec_end_ff  <= prec_end_in;
         digit_end_ff <= digit_end_in;
         count_ff     <= count_in;
         cut_ff       <= cut_in;
         pfx_two_ff   <= (pfx_len == POS_W'(2));
      end
   end

   // ------------------------------------------------------ character pipeline
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign b_move   = b_valid_ff & out_free;
   assign issue    = a_active_ff & (~b_valid_ff | b_move);

   // digits are stored least significant first
   assign rd_pos  = digit_end_ff - POS_W'(1) - k_ff;
   assign rd_addr = rd_pos[DIDX_W-1:0];

   always_comb begin
      b_digit_in = 1'b0;
      if (k_ff < lead_end_ff) begin
         b_char_in = CH_SPACE;
      end else if (k_ff < sign_end_ff) begin
         b_char_in = sign_char_ff;
      end else if (k_ff < pfx_end_ff) begin
         if (pfx_two_ff && k_ff == sign_end_ff)
            b_char_in = CH_ZERO;
         else
            b_char_in = digit_char(pfx_two_ff ? HEX_LETTER : OCT_LETTER, lower_ff);
      end else if (k_ff < prec_end_ff) begin
         b_char_in = CH_ZERO;
      end else if (k_ff < digit_end_ff) begin
         b_char_in  = CH_ZERO;
         b_digit_in = 1'b1;
      end else begin
         b_char_in = CH_SPACE;
      end
      b_last_in = (k_ff == count_ff - POS_W'(1));
   end

   always_ff @(posedge clock) begin
      if (div_done)
         digit_mem_ff[nd_ff[DIDX_W-1:0]] <= div_rem;
      if (issue)
         mem_rd_ff <= digit_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_active_ff <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else begin
         if (cmd.layout) begin
            a_active_ff <= 1'b1;
         end else if (issue && b_last_in) begin
            a_active_ff <= 1'b0;
         end
         if (issue) begin
            b_valid_ff <= 1'b1;
         end else if (b_move) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.layout) begin
         k_ff <= '0;
      end else if (issue) begin
         k_ff <= k_ff + 1'b1;
      end
      if (issue) begin
         b_char_ff  <= b_char_in;
         b_digit_ff <= b_digit_in;
         b_last_ff  <= b_last_in;
      end
   end

   // ---------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.err_send || b_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err_send) begin
         rsp_char_ff <= CH_NUL;
         rsp_last_ff <= 1'b1;
         rsp_cut_ff  <= 1'b0;
         rsp_bad_ff  <= 1'b1;
      end else if (b_move) begin
         rsp_char_ff <= b_digit_ff ? digit_char(mem_rd_ff, lower_ff) : b_char_ff;
         rsp_last_ff <= b_last_ff;
         rsp_cut_ff  <= b_last_ff & cut_ff;
         rsp_bad_ff  <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_cut_off   = rsp_cut_ff;
   assign rsp_bad_radix = rsp_bad_ff;

   assign status.req_bad   = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
   assign status.div_done  = div_done;
   assign status.quo_zero  = (div_quo == '0);
   assign status.emit_done = ~a_active_ff & ~b_valid_ff;
   assign status.out_free  = out_free;

   a_digit_room: assert property (@(posedge clock) disable iff (reset)
      div_done |-> nd_ff < ND_W'(DIGIT_SLOTS))
      else $error("digit store overflow");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> k_ff < count_ff)
      else $error("character issued past end of text");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.err_send |-> !b_valid_ff && !a_active_ff && out_free)
      else $error("error result collides with character pipeline");

endmodule

### sv/itf_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences capture, digit conversion, layout and emission.
module itf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output itf_pkg::cmd_type      cmd,
   input  itf_pkg::status_type   status
);
   import itf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = status.req_bad ? ST_ERROR : ST_DIV_START;
         end
         ST_ERROR: begin
            if (status.out_free)
               state_in = ST_IDLE;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done)
               state_in = status.quo_zero ? ST_LAYOUT : ST_DIV_START;
         end
         ST_LAYOUT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_done)
               state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      cmd.capture   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.layout    = 1'b0;
      cmd.err_send  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_ERROR: begin
            cmd.err_send = status.out_free;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         ST_LAYOUT: begin
            cmd.layout = 1'b1;
         end
         default: begin
         end
      endcase
   end

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside of a conversion step");

   a_emit_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && status.emit_done |=> state_ff == ST_IDLE)
      else $error("emission end did not return to idle");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("request taken while an item is in flight");

endmodule

### sv/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// Top level of the integer-to-text formatter.
//
// Request channel (req_*): one transfer carries a number and its printf-style
// format; it is taken when req_valid is high and req_stall is low. The block
// works on one item at a time and raises req_stall until the item's last
// character has left the character pipeline.
// Response channel (rsp_*): one ASCII character per transfer, last_char on
// the final one, cut_off on that final one when the text exceeded MAX_CHARS.
// A base outside 2..36 gives a single transfer with bad_radix set.
// Per item: a capture step, then per digit one divider pass, by shifting for
// a power-of-two base or byte-serially over the significant bytes of the
// remaining value otherwise; then a layout step and one character per cycle
// when not stalled, through a two-stage read pipeline on the digit store.
// While a valid result meets rsp_stall, the result register and pipeline
// hold; the block takes the next request while the final character still
// waits in the result register. Synchronous reset returns the controller to
// idle and empties the pipeline; the digit store needs no clearing.
module integer_to_text_formatter #(
   parameter int MAX_CHARS   = itf_pkg::MAX_CHARS_DEF,
   parameter int DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF,
   parameter int VALUE_BITS  = itf_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [itf_pkg::VALUE_W-1:0]   req_value,
   input  logic [itf_pkg::RADIX_W-1:0]   req_radix,
   input  logic [itf_pkg::COUNT_W-1:0]   req_min_width,
   input  logic [itf_pkg::COUNT_W-1:0]   req_min_digits,
   input  logic                          req_align_left,
   input  logic                          req_show_plus,
   input  logic                          req_show_space,
   input  logic                          req_with_prefix,
   input  logic                          req_zero_fill,
   input  logic                          req_signed_mode,
   input  logic                          req_lower_case,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itf_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_last_char,
   output logic                          rsp_cut_off,
   output logic                          rsp_bad_radix
);
   import itf_pkg::*;

   cmd_type    cmd;
   status_type status;

   itf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   itf_datapath #(
      .MAX_CHARS   (MAX_CHARS),
      .DIGIT_SLOTS (DIGIT_SLOTS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .req_radix       (req_radix),
      .req_min_width   (req_min_width),
      .req_min_digits  (req_min_digits),
      .req_align_left  (req_align_left),
      .req_show_plus   (req_show_plus),
      .req_show_space  (req_show_space),
      .req_with_prefix (req_with_prefix),
      .req_zero_fill   (req_zero_fill),
      .req_signed_mode (req_signed_mode),
      .req_lower_case  (req_lower_case),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_cut_off     (rsp_cut_off),
      .rsp_bad_radix   (rsp_bad_radix)
   );

endmodule
